// ===== rtl/i2cmts_pkg.sv =====
package i2cmts_pkg;

  // write buffer depth and the clamp applied to transfer lengths
  localparam int MAX_BYTES = 16;
  localparam int BUF_AW    = $clog2(MAX_BYTES);

  // item function codes
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_READ  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_POLL  = 3'd3;
  localparam logic [2:0] FUNC_RESET = 3'd4;
  localparam logic [2:0] FUNC_LOAD  = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] target_addr;
    logic [7:0] reg_addr;
    logic [4:0] length;
    logic       stop_first;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       line_oe;
    logic       line_scl;
    logic       line_sda;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       done_res;
    logic       ok;
  } out_item_t;

endpackage

// ===== rtl/i2c_master_transaction_sequencer_top.sv =====
// path: a beat accepted into the input register is registered as its result in the result
//   register once that register is free or being drained
// throughput: one beat per cycle in both directions unless out_ready stalls; every item
//   is one pass through the quarter-bit sequencer between input and result registers
// reset: rst_n is synchronous, active low; sequencer idle, lines held at oe 0 scl 1 sda 1,
//   write buffer empty, both pipeline registers empty
module i2c_master_transaction_sequencer_top
  import i2cmts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // sequencer steps
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_START1   = 4'd1;
  localparam logic [3:0] ST_TX_AW    = 4'd2;
  localparam logic [3:0] ST_TX_REG   = 4'd3;
  localparam logic [3:0] ST_MID_STOP = 4'd4;
  localparam logic [3:0] ST_START2   = 4'd5;
  localparam logic [3:0] ST_TX_AR    = 4'd6;
  localparam logic [3:0] ST_RX       = 4'd7;
  localparam logic [3:0] ST_TX_DATA  = 4'd8;
  localparam logic [3:0] ST_STOP     = 4'd9;
  localparam logic [3:0] ST_RST_HIGH = 4'd10;
  localparam logic [3:0] ST_RST_CLK  = 4'd11;
  localparam logic [3:0] ST_RST_REL  = 4'd12;
  localparam logic [3:0] ST_RST_STOP = 4'd13;
  localparam logic [3:0] ST_RST_TAIL = 4'd14;

  // line levels as {oe, scl, sda}
  localparam logic [2:0] LN_IDLE = 3'b011;

  localparam logic [4:0] MAX_LEN = 5'(MAX_BYTES);

  // input register and result register
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      advance;

  // sequencer state
  logic [3:0] step_r, step_nxt;
  logic [3:0] delay_r, delay_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [4:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       poll_ack_r, poll_ack_nxt;
  logic [2:0] line_r, line_nxt;
  logic       ack_r, ack_nxt;
  logic       result_ok_r, result_ok_nxt;
  logic [4:0] fill_r, fill_nxt;

  // latched command
  logic [2:0] kind_r, kind_nxt;
  logic [6:0] slave_r, slave_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [4:0] len_r, len_nxt;
  logic       stop_r, stop_nxt;

  // write buffer, entries read only below the fill count
  logic [7:0] wbuf_r [MAX_BYTES];
  logic       wbuf_we;

  // pipeline moves when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wbuf_we) begin
      wbuf_r[fill_r[BUF_AW-1:0]] <= in_item_r.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      delay_r     <= '0;
      bit_r       <= '0;
      byte_cnt_r  <= '0;
      shift_r     <= '0;
      poll_ack_r  <= 1'b0;
      line_r      <= LN_IDLE;
      ack_r       <= 1'b0;
      result_ok_r <= 1'b0;
      fill_r      <= '0;
      kind_r      <= FUNC_TICK;
      slave_r     <= '0;
      reg_r       <= '0;
      len_r       <= '0;
      stop_r      <= 1'b0;
    end else if (advance) begin
      step_r      <= step_nxt;
      delay_r     <= delay_nxt;
      bit_r       <= bit_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      shift_r     <= shift_nxt;
      poll_ack_r  <= poll_ack_nxt;
      line_r      <= line_nxt;
      ack_r       <= ack_nxt;
      result_ok_r <= result_ok_nxt;
      fill_r      <= fill_nxt;
      kind_r      <= kind_nxt;
      slave_r     <= slave_nxt;
      reg_r       <= reg_nxt;
      len_r       <= len_nxt;
      stop_r      <= stop_nxt;
    end
  end

  // one delay unit of the sequencer per tick beat
  logic       busy;
  logic       is_cmd;
  logic       is_tx;
  logic       hi;
  logic       endp;
  logic       bitphase;
  logic       acked;
  logic       rx_last;
  logic       enter_en;
  logic [3:0] enter_st;
  logic [3:0] delay_inc;
  logic [2:0] ln;
  logic       bvalid;
  logic [7:0] bval;
  logic       blast;
  logic       done;
  logic       okv;
  logic       busy_o;

  always_comb begin
    step_nxt      = step_r;
    delay_nxt     = delay_r;
    bit_nxt       = bit_r;
    byte_cnt_nxt  = byte_cnt_r;
    shift_nxt     = shift_r;
    poll_ack_nxt  = poll_ack_r;
    line_nxt      = line_r;
    ack_nxt       = ack_r;
    result_ok_nxt = result_ok_r;
    fill_nxt      = fill_r;
    kind_nxt      = kind_r;
    slave_nxt     = slave_r;
    reg_nxt       = reg_r;
    len_nxt       = len_r;
    stop_nxt      = stop_r;
    wbuf_we       = 1'b0;

    busy     = step_r != ST_IDLE;
    is_cmd   = in_item_r.func >= FUNC_READ && in_item_r.func <= FUNC_RESET;
    is_tx    = step_r == ST_TX_AW || step_r == ST_TX_REG ||
               step_r == ST_TX_AR || step_r == ST_TX_DATA;
    hi       = delay_r == 4'd1 || delay_r == 4'd2;
    acked    = !ack_r;
    rx_last  = (byte_cnt_r + 5'd1) >= len_r;
    delay_inc = delay_r + 4'd1;
    endp     = 1'b0;
    bitphase = 1'b0;
    enter_en = 1'b0;
    enter_st = ST_IDLE;
    ln       = line_r;
    bvalid   = 1'b0;
    bval     = '0;
    blast    = 1'b0;
    done     = 1'b0;
    okv      = 1'b0;
    busy_o   = busy;

    if (is_cmd && !busy) begin
      // start a transaction or a bus reset
      kind_nxt      = in_item_r.func;
      slave_nxt     = in_item_r.target_addr;
      reg_nxt       = in_item_r.reg_addr;
      len_nxt       = (in_item_r.length > MAX_LEN) ? MAX_LEN : in_item_r.length;
      stop_nxt      = in_item_r.stop_first;
      poll_ack_nxt  = 1'b0;
      result_ok_nxt = 1'b0;
      byte_cnt_nxt  = '0;
      enter_en      = 1'b1;
      enter_st      = (in_item_r.func == FUNC_RESET) ? ST_RST_HIGH : ST_START1;
      busy_o        = 1'b1;
    end else if (in_item_r.func == FUNC_LOAD && !busy) begin
      if (fill_r < MAX_LEN) begin
        wbuf_we  = 1'b1;
        fill_nxt = fill_r + 5'd1;
      end
    end else if (in_item_r.func == FUNC_TICK && busy) begin
      // line levels for this unit
      unique case (step_r)
        ST_START1, ST_START2: begin
          ln   = (delay_r == 4'd0) ? 3'b111 : ((delay_r == 4'd1) ? 3'b110 : 3'b100);
          endp = delay_r >= 4'd2;
        end
        ST_MID_STOP, ST_STOP, ST_RST_STOP: begin
          ln   = (delay_r == 4'd0) ? 3'b100 : ((delay_r == 4'd1) ? 3'b110 : 3'b111);
          endp = delay_r >= 4'd2;
        end
        ST_TX_AW, ST_TX_REG, ST_TX_AR, ST_TX_DATA: begin
          bitphase = 1'b1;
          if (bit_r < 4'd8) begin
            // msb first: bit index 7 - b
            ln = {1'b1, hi, shift_r[~bit_r[2:0]]};
          end else begin
            ln = {1'b0, hi, 1'b0};
            if (delay_r == 4'd2) begin
              ack_nxt = in_item_r.sda_in;
            end
          end
          endp = bit_r >= 4'd8 && delay_r >= 4'd3;
        end
        ST_RX: begin
          bitphase = 1'b1;
          if (bit_r < 4'd8) begin
            ln = {1'b0, hi, 1'b0};
            if (delay_r == 4'd2) begin
              shift_nxt = {shift_r[6:0], in_item_r.sda_in};
            end
          end else begin
            // ack every byte but the last
            ln = {1'b1, hi, rx_last};
          end
          endp = bit_r >= 4'd8 && delay_r >= 4'd3;
        end
        ST_RST_HIGH: begin
          ln   = 3'b111;
          endp = delay_r >= 4'd7;
        end
        ST_RST_CLK: begin
          bitphase = 1'b1;
          ln       = (delay_r >= 4'd2) ? 3'b111 : 3'b101;
          endp     = bit_r >= 4'd8 && delay_r >= 4'd3;
        end
        ST_RST_REL: begin
          ln   = 3'b001;
          endp = 1'b1;
        end
        default: begin
          ln   = LN_IDLE;
          endp = delay_r >= 4'd7;
        end
      endcase

      line_nxt = ln;

      if (!endp) begin
        if (bitphase && delay_inc >= 4'd4) begin
          delay_nxt = '0;
          bit_nxt   = bit_r + 4'd1;
        end else begin
          delay_nxt = delay_inc;
        end
      end else if (is_tx) begin
        enter_en = 1'b1;
        if (kind_r == FUNC_POLL) begin
          // poll passes if either address phase is acked
          poll_ack_nxt = poll_ack_r | acked;
          if (step_r == ST_TX_AW) begin
            enter_st = ST_TX_AR;
          end else begin
            result_ok_nxt = poll_ack_r | acked;
            enter_st      = ST_STOP;
          end
        end else if (!acked) begin
          result_ok_nxt = 1'b0;
          enter_st      = ST_STOP;
        end else begin
          result_ok_nxt = 1'b1;
          unique case (step_r)
            ST_TX_AW: enter_st = ST_TX_REG;
            ST_TX_REG: begin
              if (kind_r == FUNC_READ) begin
                enter_st = stop_r ? ST_MID_STOP : ST_START2;
              end else if (len_r != '0) begin
                byte_cnt_nxt = '0;
                enter_st     = ST_TX_DATA;
              end else begin
                enter_st = ST_STOP;
              end
            end
            ST_TX_AR: begin
              if (len_r != '0) begin
                byte_cnt_nxt = '0;
                enter_st     = ST_RX;
              end else begin
                enter_st = ST_STOP;
              end
            end
            default: begin
              byte_cnt_nxt = byte_cnt_r + 5'd1;
              enter_st     = (byte_cnt_nxt < len_r) ? ST_TX_DATA : ST_STOP;
            end
          endcase
        end
      end else begin
        enter_en = 1'b1;
        unique case (step_r)
          ST_RX: begin
            bvalid       = 1'b1;
            bval         = shift_r;
            blast        = rx_last;
            byte_cnt_nxt = byte_cnt_r + 5'd1;
            if (byte_cnt_nxt < len_r) begin
              enter_st = ST_RX;
            end else begin
              result_ok_nxt = 1'b1;
              enter_st      = ST_STOP;
            end
          end
          ST_START1:   enter_st = ST_TX_AW;
          ST_START2:   enter_st = ST_TX_AR;
          ST_MID_STOP: enter_st = ST_START2;
          ST_RST_HIGH: enter_st = ST_RST_CLK;
          ST_RST_CLK:  enter_st = ST_RST_REL;
          ST_RST_REL:  enter_st = ST_RST_STOP;
          ST_RST_STOP: begin
            line_nxt = LN_IDLE;
            enter_st = ST_RST_TAIL;
          end
          ST_RST_TAIL: begin
            done     = 1'b1;
            okv      = 1'b1;
            enter_st = ST_IDLE;
          end
          default: begin
            // end of the closing stop
            line_nxt = LN_IDLE;
            done     = 1'b1;
            okv      = result_ok_r;
            if (kind_r == FUNC_WRITE) begin
              fill_nxt = '0;
            end
            enter_st = ST_IDLE;
          end
        endcase
      end
    end

    // step entry: clear counters, preload the shifter
    if (enter_en) begin
      step_nxt  = enter_st;
      delay_nxt = '0;
      bit_nxt   = '0;
      unique case (enter_st)
        ST_TX_AW:  shift_nxt = {slave_r, 1'b0};
        ST_TX_AR:  shift_nxt = {slave_r, 1'b1};
        ST_TX_REG: shift_nxt = reg_r;
        ST_TX_DATA: begin
          shift_nxt = (byte_cnt_nxt < fill_r) ? wbuf_r[byte_cnt_nxt[BUF_AW-1:0]] : 8'h00;
        end
        ST_RX:     shift_nxt = '0;
        default:   ;
      endcase
    end

    out_item_nxt.line_oe    = ln[2];
    out_item_nxt.line_scl   = ln[1];
    out_item_nxt.line_sda   = ln[0];
    out_item_nxt.busy_res   = busy_o;
    out_item_nxt.byte_valid = bvalid;
    out_item_nxt.byte_value = bval;
    out_item_nxt.last_byte  = blast;
    out_item_nxt.done_res   = done;
    out_item_nxt.ok         = okv;
  end

endmodule

// ===== tb/tb_i2c_master_transaction_sequencer_top.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer_top;
  import i2cmts_pkg::*;

  // function codes the block treats as no-ops
  localparam logic [2:0] FUNC_UNUSED6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED7 = 3'd7;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_ROWS    = 20;
  localparam int LONG_HOLD   = 200;

  // quarter-bit sequencer phases, mirrored from the step codes of the design
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_START1, SQ_TX_AW, SQ_TX_REG, SQ_MID_STOP, SQ_START2, SQ_TX_AR,
    SQ_RX, SQ_TX_DATA, SQ_STOP, SQ_RST_HIGH, SQ_RST_CLK, SQ_RST_REL, SQ_RST_STOP,
    SQ_RST_TAIL
  } seq_step_e;

  // one row of the directed table: beat, and optionally a hand-written result
  typedef struct packed {
    in_item_t  beat;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  i2c_master_transaction_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // bus model state: what the sequencer should hold after every accepted beat
  // ---------------------------------------------------------------------------
  logic [7:0]  wbuf [MAX_BYTES];
  int unsigned wfill     = 0;
  seq_step_e   step      = SQ_IDLE;
  logic [3:0]  dly       = '0;
  logic [3:0]  bitn      = '0;
  int unsigned nbytes    = 0;
  logic [7:0]  shreg     = '0;
  logic        poll_hit  = 1'b0;
  logic [2:0]  lines     = 3'b011;   // oe, scl, sda
  logic [2:0]  cmd_kind  = '0;
  logic [6:0]  cmd_slave = '0;
  logic [7:0]  cmd_reg   = '0;
  int unsigned cmd_len   = 0;
  logic        cmd_stop  = 1'b0;
  logic        ack_bit   = 1'b0;
  logic        txn_ok    = 1'b0;
  logic        took_effect;

  // expected result beats, oldest first
  out_item_t   line_results_q [$];

  int          mismatches     = 0;
  int unsigned sent_count     = 0;
  int unsigned beats_effective = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;

  // receiver-side stall bookkeeping
  int unsigned hold_left      = 0;
  int unsigned stall_left     = 0;
  bit          long_hold_done = 1'b0;

  // move to a new phase and preload the shift register for it
  function automatic void enter_step(seq_step_e s);
    step = s;
    dly  = '0;
    bitn = '0;
    case (s)
      SQ_TX_AW:   shreg = {cmd_slave, 1'b0};
      SQ_TX_AR:   shreg = {cmd_slave, 1'b1};
      SQ_TX_REG:  shreg = cmd_reg;
      SQ_TX_DATA: shreg = (nbytes < wfill && nbytes < MAX_BYTES) ? wbuf[nbytes] : 8'h00;
      SQ_RX:      shreg = '0;
      default: ;
    endcase
  endfunction

  // decide where to go once a sent byte and its ack bit are through
  function automatic void finish_tx_byte();
    logic acked;
    acked = !ack_bit;
    if (cmd_kind == FUNC_POLL) begin
      // a poll sends both address bytes, either ack counts
      poll_hit = poll_hit | acked;
      if (step == SQ_TX_AW) begin
        enter_step(SQ_TX_AR);
      end else begin
        txn_ok = poll_hit;
        enter_step(SQ_STOP);
      end
    end else if (!acked) begin
      // nack: stop and report failure
      txn_ok = 1'b0;
      enter_step(SQ_STOP);
    end else begin
      txn_ok = 1'b1;
      case (step)
        SQ_TX_AW: enter_step(SQ_TX_REG);
        SQ_TX_REG: begin
          if (cmd_kind == FUNC_READ) begin
            enter_step(cmd_stop ? SQ_MID_STOP : SQ_START2);
          end else if (cmd_len > 0) begin
            nbytes = 0;
            enter_step(SQ_TX_DATA);
          end else begin
            enter_step(SQ_STOP);
          end
        end
        SQ_TX_AR: begin
          if (cmd_len > 0) begin
            nbytes = 0;
            enter_step(SQ_RX);
          end else begin
            enter_step(SQ_STOP);
          end
        end
        default: begin
          nbytes++;
          if (nbytes < cmd_len) enter_step(SQ_TX_DATA);
          else enter_step(SQ_STOP);
        end
      endcase
    end
  endfunction

  // advance the bus model by one beat and return the result beat it implies
  function automatic out_item_t predict_step(in_item_t beat);
    out_item_t res;
    seq_step_e s;
    logic [3:0] d;
    logic [3:0] b;
    logic [2:0] ln;
    logic [2:0] hi;
    logic       busy;
    logic       endp;
    logic       bitphase;
    res  = '0;
    ln   = lines;
    busy = (step != SQ_IDLE);
    s    = step;
    d    = dly;
    b    = bitn;
    took_effect = 1'b0;
    if (beat.func >= FUNC_READ && beat.func <= FUNC_RESET && !busy) begin
      // command latch; sda is ignored and no delay unit passes
      cmd_kind  = beat.func;
      cmd_slave = beat.target_addr;
      cmd_reg   = beat.reg_addr;
      cmd_len   = (beat.length > MAX_BYTES) ? MAX_BYTES : beat.length;
      cmd_stop  = beat.stop_first;
      poll_hit  = 1'b0;
      txn_ok    = 1'b0;
      nbytes    = 0;
      enter_step(beat.func == FUNC_RESET ? SQ_RST_HIGH : SQ_START1);
      busy = 1'b1;
      took_effect = 1'b1;
    end else if (beat.func == FUNC_LOAD && !busy) begin
      if (wfill < MAX_BYTES) begin
        wbuf[wfill] = beat.data_byte;
        wfill++;
        took_effect = 1'b1;
      end
    end else if (beat.func == FUNC_TICK && busy) begin
      took_effect = 1'b1;
      hi       = (d == 4'd1 || d == 4'd2) ? 3'b010 : 3'b000;
      endp     = 1'b0;
      bitphase = 1'b0;
      case (s)
        SQ_START1, SQ_START2: begin
          ln   = (d == 4'd0) ? 3'b111 : ((d == 4'd1) ? 3'b110 : 3'b100);
          endp = (d >= 4'd2);
        end
        SQ_MID_STOP, SQ_STOP, SQ_RST_STOP: begin
          ln   = (d == 4'd0) ? 3'b100 : ((d == 4'd1) ? 3'b110 : 3'b111);
          endp = (d >= 4'd2);
        end
        SQ_TX_AW, SQ_TX_REG, SQ_TX_AR, SQ_TX_DATA: begin
          bitphase = 1'b1;
          if (b < 4'd8) begin
            ln = 3'b100 | hi | {2'b00, shreg[7 - b]};
          end else begin
            // ack bit: line released, sampled mid high
            ln = hi;
            if (d == 4'd2) ack_bit = beat.sda_in;
          end
          endp = (b >= 4'd8 && d >= 4'd3);
        end
        SQ_RX: begin
          bitphase = 1'b1;
          if (b < 4'd8) begin
            ln = hi;
            if (d == 4'd2) shreg = {shreg[6:0], beat.sda_in};
          end else begin
            // master ack, high only on the final byte (nack)
            ln = 3'b100 | hi | ((nbytes + 1 >= cmd_len) ? 3'b001 : 3'b000);
          end
          endp = (b >= 4'd8 && d >= 4'd3);
        end
        SQ_RST_HIGH: begin
          ln   = 3'b111;
          endp = (d >= 4'd7);
        end
        SQ_RST_CLK: begin
          bitphase = 1'b1;
          ln   = (d >= 4'd2) ? 3'b111 : 3'b101;
          endp = (b >= 4'd8 && d >= 4'd3);
        end
        SQ_RST_REL: begin
          ln   = 3'b001;
          endp = 1'b1;
        end
        default: begin
          ln   = 3'b011;
          endp = (d >= 4'd7);
        end
      endcase
      lines = ln;
      if (!endp) begin
        dly = d + 4'd1;
        if (bitphase && dly >= 4'd4) begin
          dly  = '0;
          bitn = b + 4'd1;
        end
      end else begin
        case (s)
          SQ_TX_AW, SQ_TX_REG, SQ_TX_AR, SQ_TX_DATA: finish_tx_byte();
          SQ_RX: begin
            res.byte_valid = 1'b1;
            res.byte_value = shreg;
            res.last_byte  = (nbytes + 1 >= cmd_len);
            nbytes++;
            if (nbytes < cmd_len) begin
              enter_step(SQ_RX);
            end else begin
              txn_ok = 1'b1;
              enter_step(SQ_STOP);
            end
          end
          SQ_START1:   enter_step(SQ_TX_AW);
          SQ_START2:   enter_step(SQ_TX_AR);
          SQ_MID_STOP: enter_step(SQ_START2);
          SQ_RST_HIGH: enter_step(SQ_RST_CLK);
          SQ_RST_CLK:  enter_step(SQ_RST_REL);
          SQ_RST_REL:  enter_step(SQ_RST_STOP);
          SQ_RST_STOP: begin
            lines = 3'b011;
            enter_step(SQ_RST_TAIL);
          end
          SQ_RST_TAIL: begin
            // bus reset always succeeds
            res.done_res = 1'b1;
            res.ok       = 1'b1;
            enter_step(SQ_IDLE);
          end
          default: begin
            // end of stop: lines parked, write buffer emptied after a write
            lines        = 3'b011;
            res.done_res = 1'b1;
            res.ok       = txn_ok;
            if (cmd_kind == FUNC_WRITE) wfill = 0;
            enter_step(SQ_IDLE);
          end
        endcase
      end
    end
    res.line_oe  = ln[2];
    res.line_scl = ln[1];
    res.line_sda = ln[0];
    res.busy_res = busy;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_beat(logic [2:0] f, int slave, int rg, int len,
                                       int stp, int data, int sda);
    in_item_t b;
    b.func        = f;
    b.target_addr = slave[6:0];
    b.reg_addr    = rg[7:0];
    b.length      = len[4:0];
    b.stop_first  = stp[0];
    b.data_byte   = data[7:0];
    b.sda_in      = sda[0];
    return b;
  endfunction

  // result beat with only line levels and busy set
  function automatic out_item_t held_lines(logic [2:0] l, logic busy);
    out_item_t r;
    r          = '0;
    r.line_oe  = l[2];
    r.line_scl = l[1];
    r.line_sda = l[0];
    r.busy_res = busy;
    return r;
  endfunction

  // random beat; lengths mostly short, the odd one at or past the clamp
  function automatic in_item_t rand_beat(logic [2:0] f);
    in_item_t b;
    int       pick;
    pick = $urandom_range(0, 99);
    b.func        = f;
    b.target_addr = 7'($urandom_range(0, 127));
    b.reg_addr    = 8'($urandom_range(0, 255));
    if (pick < 20)      b.length = 5'd0;
    else if (pick < 85) b.length = 5'($urandom_range(1, 3));
    else if (pick < 95) b.length = 5'($urandom_range(4, 15));
    else                b.length = 5'($urandom_range(16, 31));
    b.stop_first  = 1'($urandom_range(0, 1));
    b.data_byte   = 8'($urandom_range(0, 255));
    b.sda_in      = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // offer one beat, hold it until accepted, then record what it should produce
  task automatic send_beat(input in_item_t beat, input logic typed = 1'b0,
                           input out_item_t want = '0);
    out_item_t pred;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = predict_step(beat);
    line_results_q.push_back(typed ? want : pred);
    sent_count++;
    if (took_effect) beats_effective++;
  endtask

  // sender goes quiet until every expected result beat is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (line_results_q.size() != 0);
  endtask

  // clock the running transaction to its end; acks mostly given so that
  // transfers get past the address phases, with some noise beats mixed in
  task automatic tick_until_idle(int ack_pct);
    in_item_t beat;
    while (step != SQ_IDLE) begin
      if (ack_pct < 100 && $urandom_range(0, 11) == 0) begin
        // commands, loads and no-ops while busy are all dropped
        beat = rand_beat(3'($urandom_range(FUNC_READ, FUNC_UNUSED7)));
      end else begin
        beat = rand_beat(FUNC_TICK);
        if ((step == SQ_TX_AW || step == SQ_TX_REG || step == SQ_TX_AR ||
             step == SQ_TX_DATA) && bitn == 4'd8)
          beat.sda_in = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
      end
      send_beat(beat);
    end
  endtask

  // loads, optional idle beats, one command, then ticks until it finishes
  task automatic run_sequence();
    int         loads;
    logic [2:0] idle_f;
    loads = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
    repeat (loads) send_beat(rand_beat(FUNC_LOAD));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        idle_f = ($urandom_range(0, 1) != 0) ? FUNC_TICK :
                 (($urandom_range(0, 1) != 0) ? FUNC_UNUSED6 : FUNC_UNUSED7);
        send_beat(rand_beat(idle_f));
      end
    end
    send_beat(rand_beat(3'($urandom_range(FUNC_READ, FUNC_RESET))));
    tick_until_idle(($urandom_range(0, 4) == 0) ? 60 : 95);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random ready with one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic rdy;
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!long_hold_done && sent_count >= 300) begin
      // long stretch with the sender still offering beats
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      rdy            = 1'b0;
    end else if (calm) begin
      rdy = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      // start a stall burst of random length
      stall_left = $urandom_range(0, 2);
      rdy        = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (line_results_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = line_results_q.pop_front();
        check_field("line_oe",    8'(want.line_oe),    8'(out_data.line_oe));
        check_field("line_scl",   8'(want.line_scl),   8'(out_data.line_scl));
        check_field("line_sda",   8'(want.line_sda),   8'(out_data.line_sda));
        check_field("busy_res",   8'(want.busy_res),   8'(out_data.busy_res));
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
        check_field("byte_value", want.byte_value,     out_data.byte_value);
        check_field("last_byte",  8'(want.last_byte),  8'(out_data.last_byte));
        check_field("done_res",   8'(want.done_res),   8'(out_data.done_res));
        check_field("ok",         8'(want.ok),         8'(out_data.ok));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    dir_rows = '{
      // idle ticks at both field extremes: lines parked at 011
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0),             1'b1, held_lines(3'b011, 1'b0)},
      '{mk_beat(FUNC_TICK, 127, 255, 31, 1, 255, 1),      1'b1, held_lines(3'b011, 1'b0)},
      // unknown functions do nothing
      '{mk_beat(FUNC_UNUSED6, 85, 170, 10, 0, 85, 0),     1'b1, held_lines(3'b011, 1'b0)},
      '{mk_beat(FUNC_UNUSED7, 127, 255, 31, 1, 255, 1),   1'b1, held_lines(3'b011, 1'b0)},
      // three write bytes loaded
      '{mk_beat(FUNC_LOAD, 0, 0, 0, 0, 8'h00, 0),         1'b1, held_lines(3'b011, 1'b0)},
      '{mk_beat(FUNC_LOAD, 0, 0, 0, 0, 8'hff, 1),         1'b1, held_lines(3'b011, 1'b0)},
      '{mk_beat(FUNC_LOAD, 0, 0, 0, 0, 8'h5a, 0),         1'b1, held_lines(3'b011, 1'b0)},
      // write past the clamp, past the loaded bytes: busy from the command beat
      '{mk_beat(FUNC_WRITE, 127, 255, 31, 1, 0, 1),       1'b1, held_lines(3'b011, 1'b1)},
      // command and load while busy are dropped
      '{mk_beat(FUNC_READ, 0, 0, 16, 0, 0, 0),            1'b1, held_lines(3'b011, 1'b1)},
      '{mk_beat(FUNC_LOAD, 0, 0, 0, 0, 8'ha5, 0),         1'b1, held_lines(3'b011, 1'b1)},
      // start condition
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 1),             1'b1, held_lines(3'b111, 1'b1)},
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0),             1'b1, held_lines(3'b110, 1'b1)},
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0),             1'b1, held_lines(3'b100, 1'b1)},
      // more dropped beats mid transfer, lines held
      '{mk_beat(FUNC_POLL, 127, 0, 0, 0, 0, 1),           1'b1, held_lines(3'b100, 1'b1)},
      '{mk_beat(FUNC_RESET, 0, 0, 0, 0, 0, 0),            1'b1, held_lines(3'b100, 1'b1)},
      '{mk_beat(FUNC_UNUSED6, 0, 0, 0, 0, 0, 1),          1'b1, held_lines(3'b100, 1'b1)},
      // first address bit, left to the bus model
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 1),             1'b0, '0},
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0),             1'b0, '0},
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 1),             1'b0, '0},
      '{mk_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0),             1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    // finish the directed write with every ack given
    tick_until_idle(100);
    wait_drained();

    // random transactions until enough beats are through
    while (beats_effective < 1200 && sent_count < 1400)
      run_sequence();
    wait_drained();

    // closing stretch without idling on either side
    calm = 1'b1;
    repeat (2) run_sequence();
    wait_drained();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
